### design/gbiou_pkg.sv
// Shared types for the generalized box IoU pipeline.
package gbiou_pkg;

    // Per-item status flags that travel down the pipeline next to the data.
    typedef struct packed {
        logic deg_iou;   // Union area is zero or negative.
        logic deg_pen;   // Enclosing area is zero or negative.
        logic neg_pen;   // Penalty numerator (enclose - union) is negative.
        logic ovf_iou;   // IoU quotient is known to exceed the quotient range.
        logic ovf_pen;   // Penalty quotient is known to exceed the quotient range.
    } gbiou_flags_t;

endpackage

### design/generalized_box_iou_core.sv
// Generalized IoU of two boxes: fully pipelined datapath with two restoring dividers.
//
// Usage:
//   The slave stream carries one box pair per transfer on s_axis_tdata. The master
//   stream returns one result per transfer: the GIoU on m_axis_tdata in signed
//   fixed point with RESULT_FRAC_BITS fraction bits, and on m_axis_tuser a degenerate
//   flag that is set when the union or the enclosing area is zero or negative.
//   Throughput is one box pair per cycle while the master side is not stalled. The
//   path from an input transfer to the result on the master side has five
//   stages for extents, products, union, numerators and range checks, one stage
//   per quotient bit in each divider, and the output register. The two dividers
//   run side by side, one quotient bit per stage.
//   The pipeline advances as a whole whenever the output register is empty or its
//   result is taken, so s_axis_tready follows m_axis_tready while a result waits.
//   A stall freezes every stage; nothing is dropped or repeated.
//   Reset (aresetn low at a clock edge) clears all valid bits; items in flight
//   are discarded and the block is ready in the next cycle.
module generalized_box_iou_core #(
    parameter int COORD_BITS       = 16,
    parameter int RESULT_FRAC_BITS = 14
) (
    input  logic                                          aclk,
    input  logic                                          aresetn,
    input  logic                                          s_axis_tvalid,
    output logic                                          s_axis_tready,
    // a_left, a_top, a_right, a_bottom, b_left, b_top, b_right, b_bottom
    input  logic [8*COORD_BITS-1:0]                       s_axis_tdata,
    output logic                                          m_axis_tvalid,
    input  logic                                          m_axis_tready,
    // giou_value, zero padding
    output logic [((RESULT_FRAC_BITS+2+7)/8)*8-1:0]       m_axis_tdata,
    // degenerate
    output logic                                          m_axis_tuser
);

    localparam int C   = COORD_BITS;
    localparam int F   = RESULT_FRAC_BITS;
    localparam int DW  = C + 1;          // Extents.
    localparam int PW  = 2 * DW;         // Products.
    localparam int AW  = PW + 4;         // Union and difference.
    localparam int QB  = F + 2;          // Quotient bits.
    localparam int W   = AW + F + 2;     // Divider datapath.
    localparam int GW  = F + 2;          // Output value.
    localparam int OW  = ((F + 2 + 7) / 8) * 8;
    localparam int RW  = F + 4;          // Result arithmetic.
    localparam logic [QB-1:0]        CAP     = QB'(1) << (F + 1);
    localparam logic signed [RW-1:0] ONE_POS = RW'(1) << F;
    localparam logic signed [RW-1:0] ONE_NEG = -(RW'(1) << F);

    logic adv;
    assign adv           = !m_axis_tvalid || m_axis_tready;
    assign s_axis_tready = adv;

    // Stage 1: corner extents.
    logic signed [C-1:0]  al, at, ar, ab, bl, bt, br, bb;
    logic signed [DW-1:0] iw_next, ih_next, ew_next, eh_next;
    logic signed [DW-1:0] aw_next, ah_next, bw_next, bh_next;
    logic signed [DW-1:0] iw_reg, ih_reg, ew_reg, eh_reg, aw_reg, ah_reg, bw_reg, bh_reg;
    logic                 v1_reg;

    assign al = s_axis_tdata[0*C +: C];
    assign at = s_axis_tdata[1*C +: C];
    assign ar = s_axis_tdata[2*C +: C];
    assign ab = s_axis_tdata[3*C +: C];
    assign bl = s_axis_tdata[4*C +: C];
    assign bt = s_axis_tdata[5*C +: C];
    assign br = s_axis_tdata[6*C +: C];
    assign bb = s_axis_tdata[7*C +: C];

    always_comb begin
        iw_next = DW'((ar < br) ? ar : br) - DW'((al > bl) ? al : bl);
        ih_next = DW'((ab < bb) ? ab : bb) - DW'((at > bt) ? at : bt);
        ew_next = DW'((ar > br) ? ar : br) - DW'((al < bl) ? al : bl);
        eh_next = DW'((ab > bb) ? ab : bb) - DW'((at < bt) ? at : bt);
        aw_next = DW'(ar) - DW'(al);
        ah_next = DW'(ab) - DW'(at);
        bw_next = DW'(br) - DW'(bl);
        bh_next = DW'(bb) - DW'(bt);
    end

    // Stage 2: the four areas.
    logic signed [PW-1:0] inter_next, area_a_next, area_b_next, enc_next;
    logic signed [PW-1:0] inter2_reg, area_a_reg, area_b_reg, enc2_reg;
    logic                 v2_reg;

    always_comb begin
        inter_next  = (iw_reg > 0 && ih_reg > 0) ? iw_reg * ih_reg : '0;
        area_a_next = aw_reg * ah_reg;
        area_b_next = bw_reg * bh_reg;
        enc_next    = ew_reg * eh_reg;
    end

    // Stage 3: union.
    logic signed [AW-1:0] uni_next;
    logic signed [AW-1:0] uni3_reg, enc3_reg;
    logic signed [PW-1:0] inter3_reg;
    logic                 v3_reg;

    assign uni_next = AW'(area_a_reg) + AW'(area_b_reg) - AW'(inter2_reg);

    // Stage 4: penalty numerator sign and magnitude, guards.
    logic signed [AW-1:0] diff_next;
    logic [AW-1:0]        mag_pen_next;
    logic [AW-1:0]        mag_pen4_reg, den_iou4_reg, den_pen4_reg;
    logic [PW-1:0]        inter4_reg;
    gbiou_pkg::gbiou_flags_t flags4_next, flags4_reg;
    logic                 v4_reg;

    always_comb begin
        diff_next            = enc3_reg - uni3_reg;
        mag_pen_next         = (diff_next < 0) ? AW'(-diff_next) : AW'(diff_next);
        flags4_next          = '0;
        flags4_next.deg_iou  = (uni3_reg <= 0);
        flags4_next.deg_pen  = (enc3_reg <= 0);
        flags4_next.neg_pen  = (diff_next < 0);
    end

    // Stage 5: scaled numerators and quotient range checks.
    logic [W-1:0] num_iou_next, num_pen_next, den_iou_next, den_pen_next;
    logic [W-1:0] num_iou5_reg, num_pen5_reg, den_iou5_reg, den_pen5_reg;
    gbiou_pkg::gbiou_flags_t flags5_next, flags5_reg;
    logic         v5_reg;

    always_comb begin
        num_iou_next        = W'(inter4_reg) << F;
        num_pen_next        = W'(mag_pen4_reg) << F;
        den_iou_next        = flags4_reg.deg_iou ? W'(1) : W'(den_iou4_reg);
        den_pen_next        = flags4_reg.deg_pen ? W'(1) : W'(den_pen4_reg);
        flags5_next         = flags4_reg;
        flags5_next.ovf_iou = (num_iou_next >= (den_iou_next << QB));
        flags5_next.ovf_pen = (num_pen_next >= (den_pen_next << QB));
    end

    // Front stages: valid bits.
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
            v4_reg <= 1'b0;
            v5_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= s_axis_tvalid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
            v4_reg <= v3_reg;
            v5_reg <= v4_reg;
        end
    end

    // Front stages: payload.
    always_ff @(posedge aclk) begin
        if (adv) begin
            iw_reg       <= iw_next;
            ih_reg       <= ih_next;
            ew_reg       <= ew_next;
            eh_reg       <= eh_next;
            aw_reg       <= aw_next;
            ah_reg       <= ah_next;
            bw_reg       <= bw_next;
            bh_reg       <= bh_next;
            inter2_reg   <= inter_next;
            area_a_reg   <= area_a_next;
            area_b_reg   <= area_b_next;
            enc2_reg     <= enc_next;
            uni3_reg     <= uni_next;
            enc3_reg     <= AW'(enc2_reg);
            inter3_reg   <= inter2_reg;
            mag_pen4_reg <= mag_pen_next;
            den_iou4_reg <= AW'(uni3_reg);
            den_pen4_reg <= AW'(enc3_reg);
            inter4_reg   <= PW'(inter3_reg);
            flags4_reg   <= flags4_next;
            num_iou5_reg <= num_iou_next;
            num_pen5_reg <= num_pen_next;
            den_iou5_reg <= den_iou_next;
            den_pen5_reg <= den_pen_next;
            flags5_reg   <= flags5_next;
        end
    end

    // Divider stages: one quotient bit of each quotient per stage, most significant first.
    logic [W-1:0]  rem_iou_reg [QB];
    logic [W-1:0]  rem_pen_reg [QB];
    logic [W-1:0]  dvi_iou_reg [QB];
    logic [W-1:0]  dvi_pen_reg [QB];
    logic [QB-1:0] q_iou_reg   [QB];
    logic [QB-1:0] q_pen_reg   [QB];
    gbiou_pkg::gbiou_flags_t flags_d_reg [QB];
    logic [QB-1:0] vd_reg;

    for (genvar j = 0; j < QB; j++) begin : g_div
        localparam int SH = QB - 1 - j;
        logic [W-1:0]  rem_i_in, rem_p_in, den_i_in, den_p_in;
        logic [QB-1:0] q_i_in, q_p_in;
        gbiou_pkg::gbiou_flags_t flags_in;
        logic          v_in;
        logic [W:0]    trial_i, trial_p;

        if (j == 0) begin : g_first
            assign rem_i_in = num_iou5_reg;
            assign rem_p_in = num_pen5_reg;
            assign den_i_in = den_iou5_reg;
            assign den_p_in = den_pen5_reg;
            assign q_i_in   = '0;
            assign q_p_in   = '0;
            assign flags_in = flags5_reg;
            assign v_in     = v5_reg;
        end else begin : g_next
            assign rem_i_in = rem_iou_reg[j-1];
            assign rem_p_in = rem_pen_reg[j-1];
            assign den_i_in = dvi_iou_reg[j-1];
            assign den_p_in = dvi_pen_reg[j-1];
            assign q_i_in   = q_iou_reg[j-1];
            assign q_p_in   = q_pen_reg[j-1];
            assign flags_in = flags_d_reg[j-1];
            assign v_in     = vd_reg[j-1];
        end

        // Trial subtraction of the shifted divisor; a borrow keeps the remainder.
        assign trial_i = {1'b0, rem_i_in} - ({1'b0, den_i_in} << SH);
        assign trial_p = {1'b0, rem_p_in} - ({1'b0, den_p_in} << SH);

        always_ff @(posedge aclk) begin
            if (!aresetn) begin
                vd_reg[j] <= 1'b0;
            end else if (adv) begin
                vd_reg[j] <= v_in;
            end
        end

        always_ff @(posedge aclk) begin
            if (adv) begin
                rem_iou_reg[j] <= trial_i[W] ? rem_i_in : trial_i[W-1:0];
                rem_pen_reg[j] <= trial_p[W] ? rem_p_in : trial_p[W-1:0];
                q_iou_reg[j]   <= q_i_in | (QB'(!trial_i[W]) << SH);
                q_pen_reg[j]   <= q_p_in | (QB'(!trial_p[W]) << SH);
                dvi_iou_reg[j] <= den_i_in;
                dvi_pen_reg[j] <= den_p_in;
                flags_d_reg[j] <= flags_in;
            end
        end
    end

    // Output stage: cap, apply guards and signs, subtract and saturate.
    gbiou_pkg::gbiou_flags_t flags_l;
    logic [QB-1:0]        q_iou_c, q_pen_c;
    logic signed [RW-1:0] iou_v, pen_v, g_v, g_sat;
    logic [GW-1:0]        giou_reg;
    logic                 degen_reg;
    logic                 out_valid_reg;

    always_comb begin
        flags_l = flags_d_reg[QB-1];
        q_iou_c = (flags_l.ovf_iou || q_iou_reg[QB-1] > CAP) ? CAP : q_iou_reg[QB-1];
        q_pen_c = (flags_l.ovf_pen || q_pen_reg[QB-1] > CAP) ? CAP : q_pen_reg[QB-1];
        iou_v   = flags_l.deg_iou ? '0 : RW'(q_iou_c);
        pen_v   = flags_l.deg_pen ? '0 :
                  (flags_l.neg_pen ? -RW'(q_pen_c) : RW'(q_pen_c));
        g_v     = iou_v - pen_v;
        g_sat   = (g_v > ONE_POS) ? ONE_POS : ((g_v < ONE_NEG) ? ONE_NEG : g_v);
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (adv) begin
            out_valid_reg <= vd_reg[QB-1];
        end
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            giou_reg  <= g_sat[GW-1:0];
            degen_reg <= flags_l.deg_iou || flags_l.deg_pen;
        end
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = OW'(giou_reg);
    assign m_axis_tuser  = degen_reg;

    // Checks.
    a_reset_clears: assert property (@(posedge aclk)
        !aresetn |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    a_accept_enters: assert property (@(posedge aclk) disable iff (!aresetn)
        s_axis_tvalid && s_axis_tready |=> v1_reg)
        else $error("accepted transfer did not enter the first stage");

    a_result_range: assert property (@(posedge aclk) disable iff (!aresetn)
        m_axis_tvalid |-> ($signed(giou_reg) <= $signed(ONE_POS[GW-1:0]))
                       && ($signed(giou_reg) >= $signed(ONE_NEG[GW-1:0])))
        else $error("GIoU value outside its saturation range");

    a_degen_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        vd_reg[QB-1] && flags_l.deg_iou && flags_l.deg_pen |-> g_v == '0)
        else $error("fully degenerate item gave a nonzero result");

endmodule
